FILE: design/lcs_fuzzy_match_scorer_defines.svh
// Assertion helpers for the module that carries checks.
`ifndef LCS_FUZZY_MATCH_SCORER_DEFINES_SVH
`define LCS_FUZZY_MATCH_SCORER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfm assertion failed");

// Next-cycle implication, checked outside reset.
`define LFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfm assertion failed");

`endif

FILE: design/lfm_pkg.sv
`default_nettype none

package lfm_pkg;

    // Term capacity and the widths that follow from it.
    localparam int MAX_TERM  = 32;
    localparam int IDX_W     = $clog2(MAX_TERM);
    localparam int CNT_W     = $clog2(MAX_TERM + 1);

    // Fixed field and register widths.
    localparam int CHAR_W    = 16;
    localparam int FCNT_W    = 16;
    localparam int LEN_W     = 6;
    localparam int SCORE_W   = 18;
    localparam int Q16_W     = 17;
    localparam int PEN_W     = 18;
    localparam int SPAN_W    = 6;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;

    // Shared divider widths.
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam logic [Q16_W-1:0]  ONE_Q16   = 17'd65536;
    localparam logic [FCNT_W-1:0] FCNT_MAX  = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_FIELD  = 2'd2,
        ACT_END    = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS    = 2'd0,
        REG_PENALTY = 2'd1,
        REG_BONUS   = 2'd2,
        REG_SPAN    = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_PREP,
        SC_BASE_GO,
        SC_BASE_WAIT,
        SC_RATIO_GO,
        SC_RATIO_WAIT,
        SC_MUL_A,
        SC_MUL_B,
        SC_MUL_C,
        SC_MUL_D,
        SC_BONUS_GO,
        SC_BONUS_WAIT,
        SC_MIX,
        SC_DONE
    } sc_state_t;

    typedef struct packed {
        action_t            action;
        logic [CHAR_W-1:0]  char_code;
    } in_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [LEN_W-1:0]          lcs_length;
        logic [LEN_W-1:0]          longest_run;
        logic [LEN_W-1:0]          prefix_match;
    } out_t;

    typedef struct packed {
        logic [Q16_W-1:0]  bias;
        logic [PEN_W-1:0]  penalty;
        logic [Q16_W-1:0]  bonus;
        logic [SPAN_W-1:0] span;
    } cfg_t;

    // An item travelling down the cell row. For an append, pos is the write
    // slot and hit says whether there is room; for a field character, pos is
    // the field position and hit is set by the cell that extends the prefix.
    typedef struct packed {
        logic               valid;
        action_t            kind;
        logic [CHAR_W-1:0]  ch;
        logic [CNT_W-1:0]   cnt;
        logic [CNT_W-1:0]   pos;
        logic [FCNT_W-1:0]  fcnt;
        logic               hit;
        logic [CNT_W-1:0]   left;
        logic [CNT_W-1:0]   diag;
        logic [CNT_W-1:0]   rdiag;
        logic [CNT_W-1:0]   best;
        logic [CNT_W-1:0]   lval;
    } tok_t;

    // Lower-case ASCII letters only.
    function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 16'h0041 && c <= 16'h005A)
        begin
            r = c + 16'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/lcs_fuzzy_match_scorer.sv
// Fuzzy match scorer over a longest-common-subsequence table.
// Input channel (in_valid/in_ready, in_item): each item carries an action and
// a UTF-16 code unit. Clear and append build the search term (up to 32
// characters); field characters update the table; end field yields one
// result item on the output channel (out_valid/out_ready, out_item).
// Configuration registers are written through cfg_we/cfg_index/cfg_data with
// no wait; the user must write them only while the block is idle, and the block itself does not enforce this.
// Items travel down a row of 32 cells, one cell per cycle, so the block takes
// one item per cycle while no end field is waiting at the tail. When the score
// is trivially zero, the scorer goes from its preparation step straight to the
// result; otherwise the iterative divider, shared by three quotients of up to
// 48 bits, works out each of them in turn. While the scorer is
// busy or its result is not yet taken, an end field at the tail holds the
// whole row and in_ready is low. When the receiver stalls, the result stays
// in the output register unchanged.
// Reset clears the term, the table, the counters and the configuration to
// its defaults; no clearing pass is needed.
`default_nettype none

`include "lcs_fuzzy_match_scorer_defines.svh"

module lcs_fuzzy_match_scorer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire lfm_pkg::in_t                  in_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output lfm_pkg::out_t                      out_item,
    input  wire logic                          cfg_we,
    input  wire logic [lfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lfm_pkg::CFG_W-1:0]     cfg_data
);

    lfm_pkg::cfg_t              cfg_reg, cfg_next;
    logic [lfm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [lfm_pkg::CNT_W-1:0]  pos_reg, pos_next;
    logic [lfm_pkg::FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic [lfm_pkg::CNT_W-1:0]  pref_reg, pref_next;
    logic                       alive_reg, alive_next;

    lfm_pkg::tok_t              chain [0:lfm_pkg::MAX_TERM];
    lfm_pkg::tok_t              head;
    lfm_pkg::tok_t              tail;
    logic                       advance;
    logic                       sc_idle;
    logic                       sc_load;
    logic                       accept;
    logic [lfm_pkg::CHAR_W-1:0] ch_low;
    logic [16:0]                cfg_q16;

    // Configuration writes, with Q1.16 weights saturated to 1.0.
    always_comb
    begin
        cfg_next = cfg_reg;
        cfg_q16  = cfg_data[16:0];
        if (cfg_q16 > lfm_pkg::ONE_Q16)
        begin
            cfg_q16 = lfm_pkg::ONE_Q16;
        end
        if (cfg_we)
        begin
            case (lfm_pkg::cfg_reg_t'(cfg_index))
                lfm_pkg::REG_BIAS:    cfg_next.bias    = cfg_q16;
                lfm_pkg::REG_PENALTY: cfg_next.penalty = cfg_data;
                lfm_pkg::REG_BONUS:   cfg_next.bonus   = cfg_q16;
                lfm_pkg::REG_SPAN:    cfg_next.span    = cfg_data[lfm_pkg::SPAN_W-1:0];
                default:              cfg_next         = cfg_reg;
            endcase
        end
    end

    // Head: term and field counters, and the item entering the row.
    always_comb
    begin
        accept    = in_valid && advance;
        ch_low    = lfm_pkg::lower_ascii(in_item.char_code);
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        fcnt_next = fcnt_reg;
        head       = '0;
        head.valid = in_valid;
        head.kind  = in_item.action;
        head.ch    = ch_low;
        head.cnt   = cnt_reg;
        head.pos   = pos_reg;
        head.fcnt  = fcnt_reg;
        case (in_item.action)
            lfm_pkg::ACT_CLEAR:
            begin
                cnt_next  = '0;
                pos_next  = '0;
                fcnt_next = '0;
            end
            lfm_pkg::ACT_APPEND:
            begin
                head.pos = cnt_reg;
                head.hit = cnt_reg < lfm_pkg::CNT_W'(lfm_pkg::MAX_TERM);
                if (head.hit)
                begin
                    cnt_next = cnt_reg + lfm_pkg::CNT_W'(1);
                end
                pos_next  = '0;
                fcnt_next = '0;
            end
            lfm_pkg::ACT_FIELD:
            begin
                if (pos_reg < lfm_pkg::CNT_W'(lfm_pkg::MAX_TERM))
                begin
                    pos_next = pos_reg + lfm_pkg::CNT_W'(1);
                end
                if (fcnt_reg != lfm_pkg::FCNT_MAX)
                begin
                    fcnt_next = fcnt_reg + lfm_pkg::FCNT_W'(1);
                end
            end
            lfm_pkg::ACT_END:
            begin
                pos_next  = '0;
                fcnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    assign chain[0] = head;

    // Row of cells, one per term character.
    for (genvar j = 0; j < lfm_pkg::MAX_TERM; j++)
    begin : g_cell
        lfm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .cell_idx (lfm_pkg::IDX_W'(j)),
            .tok_in   (chain[j]),
            .tok_out  (chain[j+1])
        );
    end

    // Tail: prefix tracking and hand-over to the scorer.
    always_comb
    begin
        tail       = chain[lfm_pkg::MAX_TERM];
        advance    = !(tail.valid && tail.kind == lfm_pkg::ACT_END && !sc_idle);
        sc_load    = advance && tail.valid && tail.kind == lfm_pkg::ACT_END;
        pref_next  = pref_reg;
        alive_next = alive_reg;
        if (advance && tail.valid)
        begin
            case (tail.kind)
                lfm_pkg::ACT_FIELD:
                begin
                    if (alive_reg && tail.hit)
                    begin
                        pref_next = pref_reg + lfm_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        alive_next = 1'b0;
                    end
                end
                default:
                begin
                    pref_next  = '0;
                    alive_next = 1'b1;
                end
            endcase
        end
    end

    lfm_scorer u_scorer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (sc_load),
        .tok       (tail),
        .pcount    (pref_reg),
        .cfg       (cfg_reg),
        .idle      (sc_idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bias    <= 17'd32768;
            cfg_reg.penalty <= 18'd65536;
            cfg_reg.bonus   <= 17'd16384;
            cfg_reg.span    <= 6'd4;
            cnt_reg         <= '0;
            pos_reg         <= '0;
            fcnt_reg        <= '0;
            pref_reg        <= '0;
            alive_reg       <= 1'b1;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            pref_reg  <= pref_next;
            alive_reg <= alive_next;
            if (accept)
            begin
                cnt_reg  <= cnt_next;
                pos_reg  <= pos_next;
                fcnt_reg <= fcnt_next;
            end
        end
    end

    // out_valid is low in the cycle after a result is taken.
    `LFM_ASSERT_NEXT(a_out_gap, clk, rst_n, out_valid && out_ready, !out_valid)
    // At the tail, the run never exceeds the subsequence, nor that the term.
    `LFM_ASSERT_NOW(a_tail_order, clk, rst_n, tail.valid && tail.kind == lfm_pkg::ACT_END, (tail.best <= tail.lval) && (tail.lval <= tail.cnt))
    // The prefix count never runs past the term capacity.
    `LFM_ASSERT_NOW(a_pref_bound, clk, rst_n, 1'b1, pref_reg <= lfm_pkg::CNT_W'(lfm_pkg::MAX_TERM))

endmodule

`default_nettype wire

FILE: design/lfm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module lfm_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [lfm_pkg::DIV_NUM_W-1:0]  num,
    input  wire logic [lfm_pkg::DIV_DEN_W-1:0]  den,
    output logic                                busy,
    output logic [lfm_pkg::DIV_NUM_W-1:0]       quo
);

    logic [lfm_pkg::DIV_NUM_W-1:0] q_reg, q_next;
    logic [lfm_pkg::DIV_DEN_W:0]   r_reg, r_next;
    logic [lfm_pkg::DIV_DEN_W-1:0] d_reg, d_next;
    logic [lfm_pkg::DIV_CNT_W-1:0] n_reg, n_next;
    logic                          run_reg, run_next;
    logic [lfm_pkg::DIV_DEN_W:0]   r_sh;

    // One shift-and-subtract step.
    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        n_next   = n_reg;
        run_next = run_reg;
        r_sh     = {r_reg[lfm_pkg::DIV_DEN_W-1:0], q_reg[lfm_pkg::DIV_NUM_W-1]};
        if (start)
        begin
            q_next   = num;
            r_next   = '0;
            d_next   = den;
            n_next   = lfm_pkg::DIV_CNT_W'(lfm_pkg::DIV_NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = r_sh - {1'b0, d_reg};
                q_next = {q_reg[lfm_pkg::DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                q_next = {q_reg[lfm_pkg::DIV_NUM_W-2:0], 1'b0};
            end
            n_next = n_reg - lfm_pkg::DIV_CNT_W'(1);
            if (n_reg == lfm_pkg::DIV_CNT_W'(1))
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            n_reg   <= '0;
        end
        else
        begin
            run_reg <= run_next;
            n_reg   <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = run_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

FILE: design/lfm_cell.sv
`default_nettype none

// One term character with its column of the subsequence and run rows.
module lfm_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic [lfm_pkg::IDX_W-1:0] cell_idx,
    input  wire lfm_pkg::tok_t             tok_in,
    output lfm_pkg::tok_t                  tok_out
);

    logic [lfm_pkg::CHAR_W-1:0] term_reg, term_next;
    logic [lfm_pkg::CNT_W-1:0]  sub_reg, sub_next;
    logic [lfm_pkg::CNT_W-1:0]  run_reg, run_next;
    logic [lfm_pkg::CNT_W-1:0]  best_reg, best_next;
    lfm_pkg::tok_t              tok_reg, tok_next;

    logic [lfm_pkg::CNT_W-1:0]  idx_ext;
    logic                       active;
    logic                       eq;
    logic                       last;
    logic [lfm_pkg::CNT_W-1:0]  nv;
    logic [lfm_pkg::CNT_W-1:0]  nr;

    // Recurrence for this column.
    always_comb
    begin
        idx_ext = lfm_pkg::CNT_W'(cell_idx);
        active  = idx_ext < tok_in.cnt;
        eq      = tok_in.ch == term_reg;
        last    = (idx_ext + lfm_pkg::CNT_W'(1)) == tok_in.cnt;
        if (eq)
        begin
            nv = tok_in.diag + lfm_pkg::CNT_W'(1);
            nr = tok_in.rdiag + lfm_pkg::CNT_W'(1);
        end
        else
        begin
            nv = (tok_in.left > sub_reg) ? tok_in.left : sub_reg;
            nr = '0;
        end
    end

    // Item handling.
    always_comb
    begin
        term_next = term_reg;
        sub_next  = sub_reg;
        run_next  = run_reg;
        best_next = best_reg;
        tok_next  = tok_in;
        if (tok_in.valid)
        begin
            case (tok_in.kind)
                lfm_pkg::ACT_CLEAR:
                begin
                    sub_next  = '0;
                    run_next  = '0;
                    best_next = '0;
                end
                lfm_pkg::ACT_APPEND:
                begin
                    sub_next  = '0;
                    run_next  = '0;
                    best_next = '0;
                    if (tok_in.hit && tok_in.pos == idx_ext)
                    begin
                        term_next = tok_in.ch;
                    end
                end
                lfm_pkg::ACT_FIELD:
                begin
                    if (active)
                    begin
                        sub_next       = nv;
                        run_next       = nr;
                        best_next      = (nr > best_reg) ? nr : best_reg;
                        tok_next.left  = nv;
                        tok_next.diag  = sub_reg;
                        tok_next.rdiag = run_reg;
                        if (eq && tok_in.pos == idx_ext)
                        begin
                            tok_next.hit = 1'b1;
                        end
                    end
                end
                lfm_pkg::ACT_END:
                begin
                    if (active && best_reg > tok_in.best)
                    begin
                        tok_next.best = best_reg;
                    end
                    if (last)
                    begin
                        tok_next.lval = sub_reg;
                    end
                    sub_next  = '0;
                    run_next  = '0;
                    best_next = '0;
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg  <= '0;
            run_reg  <= '0;
            best_reg <= '0;
            tok_reg  <= '0;
        end
        else if (en)
        begin
            sub_reg  <= sub_next;
            run_reg  <= run_next;
            best_reg <= best_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg <= term_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: design/lfm_scorer.sv
`default_nettype none

// Turns the counts of a finished field into the Q1.16 score.
module lfm_scorer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire lfm_pkg::tok_t             tok,
    input  wire logic [lfm_pkg::CNT_W-1:0] pcount,
    input  wire lfm_pkg::cfg_t             cfg,
    output logic                           idle,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output lfm_pkg::out_t                  out_item
);

    lfm_pkg::sc_state_t state_reg, state_next;

    logic [lfm_pkg::CNT_W-1:0]  l_reg, r_reg, p_reg, t_reg;
    logic [lfm_pkg::FCNT_W-1:0] f_reg;
    logic [21:0]                num_reg;
    logic [31:0]                f2_reg;
    logic [11:0]                l2_reg;
    logic [16:0]                base_reg;
    logic [16:0]                ratio_reg;
    logic [34:0]                pa_reg;
    logic [34:0]                plo_reg;
    logic [33:0]                phi_reg;
    logic [19:0]                pen_reg;
    logic [16:0]                bonus_reg;
    logic signed [17:0]         score_reg;

    logic                          div_start;
    logic                          div_busy;
    logic [lfm_pkg::DIV_NUM_W-1:0] div_num;
    logic [lfm_pkg::DIV_DEN_W-1:0] div_den;
    logic [lfm_pkg::DIV_NUM_W-1:0] div_quo;

    logic                          zero;
    logic [31:0]                   sq_sum;
    logic [31:0]                   sq_diff;
    logic [lfm_pkg::SPAN_W-1:0]    span_eff;
    logic [lfm_pkg::SPAN_W-1:0]    pm;
    logic [52:0]                   pen_sum;
    logic signed [21:0]            pre;
    logic signed [17:0]            wgt;
    logic signed [39:0]            prod;
    logic signed [40:0]            mix;
    logic signed [24:0]            sc_wide;
    logic signed [17:0]            sc_sat;

    lfm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfm_pkg::SC_IDLE:
            begin
                if (load)
                begin
                    state_next = lfm_pkg::SC_PREP;
                end
            end
            lfm_pkg::SC_PREP:
            begin
                state_next = zero ? lfm_pkg::SC_DONE : lfm_pkg::SC_BASE_GO;
            end
            lfm_pkg::SC_BASE_GO:    state_next = lfm_pkg::SC_BASE_WAIT;
            lfm_pkg::SC_BASE_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = lfm_pkg::SC_RATIO_GO;
                end
            end
            lfm_pkg::SC_RATIO_GO:   state_next = lfm_pkg::SC_RATIO_WAIT;
            lfm_pkg::SC_RATIO_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = lfm_pkg::SC_MUL_A;
                end
            end
            lfm_pkg::SC_MUL_A:      state_next = lfm_pkg::SC_MUL_B;
            lfm_pkg::SC_MUL_B:      state_next = lfm_pkg::SC_MUL_C;
            lfm_pkg::SC_MUL_C:      state_next = lfm_pkg::SC_MUL_D;
            lfm_pkg::SC_MUL_D:      state_next = lfm_pkg::SC_BONUS_GO;
            lfm_pkg::SC_BONUS_GO:   state_next = lfm_pkg::SC_BONUS_WAIT;
            lfm_pkg::SC_BONUS_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = lfm_pkg::SC_MIX;
                end
            end
            lfm_pkg::SC_MIX:        state_next = lfm_pkg::SC_DONE;
            lfm_pkg::SC_DONE:
            begin
                if (out_ready)
                begin
                    state_next = lfm_pkg::SC_IDLE;
                end
            end
            default:                state_next = lfm_pkg::SC_IDLE;
        endcase
    end

    // Outputs and divider operands.
    always_comb
    begin
        idle      = state_reg == lfm_pkg::SC_IDLE;
        out_valid = state_reg == lfm_pkg::SC_DONE;
        div_start = 1'b0;
        span_eff  = (cfg.span == '0) ? lfm_pkg::SPAN_W'(1) : cfg.span;
        pm        = (p_reg < span_eff) ? p_reg : span_eff;
        sq_sum    = f2_reg + 32'(l2_reg);
        sq_diff   = f2_reg - 32'(l2_reg);
        div_num   = lfm_pkg::DIV_NUM_W'(num_reg) + lfm_pkg::DIV_NUM_W'(t_reg >> 1);
        div_den   = lfm_pkg::DIV_DEN_W'(t_reg);
        case (state_reg)
            lfm_pkg::SC_BASE_GO:
            begin
                div_start = 1'b1;
            end
            lfm_pkg::SC_RATIO_GO:
            begin
                div_start = 1'b1;
                div_num   = {sq_diff, 16'd0} + lfm_pkg::DIV_NUM_W'(sq_sum >> 1);
                div_den   = sq_sum;
            end
            lfm_pkg::SC_BONUS_GO:
            begin
                div_start = 1'b1;
                div_num   = lfm_pkg::DIV_NUM_W'(23'(pm) * 23'(cfg.bonus))
                          + lfm_pkg::DIV_NUM_W'(span_eff >> 1);
                div_den   = lfm_pkg::DIV_DEN_W'(span_eff);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Arithmetic for the final blend.
    always_comb
    begin
        zero    = (l_reg == '0) || (t_reg == '0) || (f_reg == '0);
        pen_sum = {phi_reg, 18'd0} + 53'(plo_reg) + 53'h0_0000_8000_0000;
        pre     = $signed({5'd0, base_reg}) - $signed({2'd0, pen_reg});
        wgt     = $signed({1'b0, lfm_pkg::ONE_Q16 - bonus_reg});
        prod    = pre * wgt;
        mix     = 41'(prod) + $signed({8'd0, bonus_reg, 16'd0})
                + 41'sd32768;
        sc_wide = 25'(mix >>> 16);
        if (sc_wide > 25'sd131071)
        begin
            sc_sat = 18'sd131071;
        end
        else if (sc_wide < -25'sd131072)
        begin
            sc_sat = -18'sd131072;
        end
        else
        begin
            sc_sat = 18'(sc_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfm_pkg::SC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers, loaded step by step.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lfm_pkg::SC_IDLE:
            begin
                l_reg <= tok.lval;
                r_reg <= tok.best;
                t_reg <= tok.cnt;
                f_reg <= tok.fcnt;
                p_reg <= pcount;
            end
            lfm_pkg::SC_PREP:
            begin
                num_reg   <= 22'(l_reg) * 22'(lfm_pkg::ONE_Q16 - cfg.bias)
                           + 22'(r_reg) * 22'(cfg.bias);
                f2_reg    <= f_reg * f_reg;
                l2_reg    <= 12'(l_reg) * 12'(l_reg);
                score_reg <= '0;
            end
            lfm_pkg::SC_BASE_WAIT:  base_reg  <= div_quo[16:0];
            lfm_pkg::SC_RATIO_WAIT: ratio_reg <= div_quo[16:0];
            lfm_pkg::SC_MUL_A:      pa_reg    <= ratio_reg * cfg.penalty;
            lfm_pkg::SC_MUL_B:      plo_reg   <= base_reg * pa_reg[17:0];
            lfm_pkg::SC_MUL_C:      phi_reg   <= base_reg * pa_reg[34:18];
            lfm_pkg::SC_MUL_D:      pen_reg   <= pen_sum[51:32];
            lfm_pkg::SC_BONUS_WAIT: bonus_reg <= div_quo[16:0];
            lfm_pkg::SC_MIX:        score_reg <= sc_sat;
            default:
            begin
                score_reg <= score_reg;
            end
        endcase
    end

    assign out_item.score        = score_reg;
    assign out_item.lcs_length   = lfm_pkg::LEN_W'(l_reg);
    assign out_item.longest_run  = lfm_pkg::LEN_W'(r_reg);
    assign out_item.prefix_match = lfm_pkg::LEN_W'(p_reg);

endmodule

`default_nettype wire

FILE: tb/sv/lcs_fuzzy_match_scorer_checker.sv
`default_nettype none

module lcs_fuzzy_match_scorer_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire lfm_pkg::in_t                  in_item,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire lfm_pkg::out_t                 out_item,
    input  wire logic                          cfg_we,
    input  wire logic [lfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lfm_pkg::CFG_W-1:0]     cfg_data,
    output int                                 fail_count,
    output int                                 pending_scores
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfm_pkg::*;

    // Shadow copy of the configuration.
    logic [16:0] bias_q;
    logic [17:0] pen_q;
    logic [16:0] bonus_q;
    logic [5:0]  span_q;

    // Shadow copy of the term and the table row.
    logic [15:0] term_chars [MAX_TERM];
    int          term_len;
    int          subseq [MAX_TERM];
    int          runs [MAX_TERM];
    int          best_len;
    int          field_len;
    int          prefix_len;
    bit          prefix_live;

    out_t        score_queue [$];
    int          mismatches;

    assign pending_scores = score_queue.size();
    assign fail_count = mismatches;

    function automatic logic [15:0] fold_case(logic [15:0] c);
        if (c >= 16'h41 && c <= 16'h5A)
        begin
            return c + 16'd32;
        end
        return c;
    endfunction

    task automatic restart_field();
        for (int j = 0; j < MAX_TERM; j++)
        begin
            subseq[j] = 0;
            runs[j] = 0;
        end
        best_len = 0;
        field_len = 0;
        prefix_len = 0;
        prefix_live = 1'b1;
    endtask

    task automatic absorb_char(logic [15:0] c);
        int diag;
        int rdiag;
        int left;
        int up;
        int rup;
        int nv;
        int nr;
        diag = 0;
        rdiag = 0;
        left = 0;
        for (int j = 0; j < term_len; j++)
        begin
            up = subseq[j];
            rup = runs[j];
            if (c == term_chars[j])
            begin
                nv = diag + 1;
                nr = rdiag + 1;
                if (nr > best_len)
                begin
                    best_len = nr;
                end
            end
            else
            begin
                nv = (left > up) ? left : up;
                nr = 0;
            end
            subseq[j] = nv;
            runs[j] = nr;
            diag = up;
            rdiag = rup;
            left = nv;
        end
        if (prefix_live && prefix_len < term_len && c == term_chars[prefix_len])
        begin
            prefix_len++;
        end
        else
        begin
            prefix_live = 1'b0;
        end
        if (field_len < 65535)
        begin
            field_len++;
        end
    endtask

    // Fixed-point score of the current field.
    function automatic longint match_score(int l, int r, int p);
        longint unsigned t;
        longint unsigned f;
        longint unsigned s;
        longint unsigned base;
        longint unsigned f2;
        longint unsigned l2;
        longint unsigned ratio;
        longint unsigned penalty;
        longint unsigned pm;
        longint unsigned bon;
        longint pre;
        longint v;
        longint sc;
        t = term_len;
        f = field_len;
        s = (span_q == 0) ? 1 : span_q;
        if (l == 0 || t == 0 || f == 0)
        begin
            return 0;
        end
        base = (longint'(l) * (65536 - bias_q) + longint'(r) * bias_q + t / 2) / t;
        f2 = f * f;
        l2 = longint'(l) * l;
        ratio = (((f2 - l2) << 16) + (f2 + l2) / 2) / (f2 + l2);
        penalty = (base * ratio * pen_q + (64'd1 << 31)) >> 32;
        pre = longint'(base) - longint'(penalty);
        pm = (p < s) ? p : s;
        bon = (pm * bonus_q + s / 2) / s;
        v = pre * longint'(65536 - bon) + longint'(65536 * bon) + 32768;
        sc = v >>> 16;
        if (sc > 131071)
        begin
            sc = 131071;
        end
        if (sc < -131072)
        begin
            sc = -131072;
        end
        return sc;
    endfunction

    // Register writes and accepted input items update the shadow state.
    always @(posedge clk or negedge rst_n)
    begin
        out_t        exp_item;
        logic [15:0] c;
        int          l;
        if (!rst_n)
        begin
            bias_q = 17'd32768;
            pen_q = 18'd65536;
            bonus_q = 17'd16384;
            span_q = 6'd4;
            term_len = 0;
            restart_field();
            score_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BIAS:    bias_q = (cfg_data[16:0] > 17'd65536) ? 17'd65536
                                                                       : cfg_data[16:0];
                    REG_PENALTY: pen_q = cfg_data[17:0];
                    REG_BONUS:   bonus_q = (cfg_data[16:0] > 17'd65536) ? 17'd65536
                                                                        : cfg_data[16:0];
                    REG_SPAN:    span_q = cfg_data[5:0];
                    default:     ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                c = fold_case(in_item.char_code);
                case (in_item.action)
                    ACT_CLEAR:
                    begin
                        term_len = 0;
                        restart_field();
                    end
                    ACT_APPEND:
                    begin
                        if (term_len < MAX_TERM)
                        begin
                            term_chars[term_len] = c;
                            term_len++;
                        end
                        restart_field();
                    end
                    ACT_FIELD:
                        absorb_char(c);
                    default:
                    begin
                        l = (term_len > 0) ? subseq[term_len-1] : 0;
                        exp_item.score = 18'(match_score(l, best_len, prefix_len));
                        exp_item.lcs_length = 6'(l);
                        exp_item.longest_run = 6'(best_len);
                        exp_item.prefix_match = 6'(prefix_len);
                        score_queue.push_back(exp_item);
                        restart_field();
                    end
                endcase
            end
        end
    end

    // Compare each result item with the oldest expected score.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            mismatches = 0;
        end
        else if (out_valid && out_ready)
        begin
            if (score_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result item: %h", out_item);
                end
            end
            else
            begin
                want = score_queue.pop_front();
                if (want !== out_item)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected score %0d lcs %0d run %0d prefix %0d,",
                                 want.score, want.lcs_length, want.longest_run,
                                 want.prefix_match);
                        $display("          got      score %0d lcs %0d run %0d prefix %0d",
                                 out_item.score, out_item.lcs_length,
                                 out_item.longest_run, out_item.prefix_match);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_lcs_fuzzy_match_scorer.sv
`default_nettype none

module tb_lcs_fuzzy_match_scorer;
    timeunit 1ns;
    timeprecision 1ps;

    import lfm_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_t                  in_item;
    logic                 out_valid;
    logic                 out_ready;
    out_t                 out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending_scores;
    int                   cycle_count;
    bit                   idle_enabled;
    bit                   hold_receiver;

    // Shadow of the term contents, so field text can be built from it.
    logic [15:0]          term_text [$];

    lcs_fuzzy_match_scorer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lcs_fuzzy_match_scorer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_scores (pending_scores)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 900000)
            begin
                $display("tb_lcs_fuzzy_match_scorer: FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold when asked.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_receiver = 1'b0;
            end
            out_ready <= !(idle_enabled && $urandom_range(99) < 7);
        end
    end

    // Offer one item and wait until it is taken. Valid stays high after the
    // item is taken; only an idle cycle or a drain lowers it.
    task automatic send_item(action_t act, logic [15:0] ch);
        while (idle_enabled && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.action <= act;
        in_item.char_code <= ch;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (act == ACT_APPEND && term_text.size() < MAX_TERM)
        begin
            term_text.push_back(ch);
        end
        if (act == ACT_CLEAR)
        begin
            term_text.delete();
        end
    endtask

    task automatic drain_scores();
        in_valid <= 1'b0;
        while (pending_scores != 0)
        begin
            @(posedge clk);
        end
        repeat (250) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random character: mostly letters in either case, sometimes anything.
    function automatic logic [15:0] rand_char();
        int k;
        k = $urandom_range(9);
        if (k < 4)
        begin
            return 16'(16'h61 + $urandom_range(5));
        end
        if (k < 7)
        begin
            return 16'(16'h41 + $urandom_range(5));
        end
        if (k < 8)
        begin
            return 16'($urandom_range(16'h40, 16'h5B));
        end
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // Field text drawn from the term, mutated now and then.
    task automatic send_field(int len);
        logic [15:0] ch;
        int          pos;
        pos = $urandom_range(2) == 0 ? 0 : $urandom_range(3);
        for (int i = 0; i < len; i++)
        begin
            if (term_text.size() > 0 && $urandom_range(9) < 7)
            begin
                ch = term_text[pos % term_text.size()];
                if ($urandom_range(1) == 1 && ch >= 16'h61 && ch <= 16'h7A)
                begin
                    ch = ch - 16'd32;
                end
                pos++;
            end
            else
            begin
                ch = rand_char();
            end
            send_item(ACT_FIELD, ch);
        end
        send_item(ACT_END, rand_char());
    endtask

    task automatic new_term(int len);
        send_item(ACT_CLEAR, 16'($urandom_range(16'hFFFF)));
        for (int i = 0; i < len; i++)
        begin
            send_item(ACT_APPEND, rand_char());
        end
    endtask

    task automatic random_config();
        write_reg(REG_BIAS, $urandom_range(2) == 0 ? 18'($urandom_range(131071))
                                                   : 18'($urandom_range(65536)));
        write_reg(REG_PENALTY, 18'($urandom_range(262143)));
        write_reg(REG_BONUS, $urandom_range(2) == 0 ? 18'($urandom_range(131071))
                                                    : 18'($urandom_range(65536)));
        write_reg(REG_SPAN, 18'($urandom_range(63)));
    endtask

    initial
    begin
        int sent;
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_enabled = 1'b0;
        hold_receiver = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty term, empty field, exact match, case folding.
        send_item(ACT_END, 16'h0);
        send_item(ACT_FIELD, 16'h61);
        send_item(ACT_END, 16'h0);
        send_item(ACT_APPEND, 16'h41);
        send_item(ACT_APPEND, 16'h62);
        send_item(ACT_END, 16'h0);
        send_item(ACT_FIELD, 16'h61);
        send_item(ACT_FIELD, 16'h42);
        send_item(ACT_END, 16'hFFFF);
        send_item(ACT_FIELD, 16'h7A);
        send_item(ACT_END, 16'h0);
        // Term change in the middle of a field restarts it.
        send_item(ACT_FIELD, 16'h61);
        send_item(ACT_APPEND, 16'h5A);
        send_item(ACT_FIELD, 16'hFFFF);
        send_item(ACT_FIELD, 16'h62);
        send_item(ACT_END, 16'h0);
        // Term overflow: 36 appends, only the first 32 kept.
        new_term(36);
        send_field(40);
        drain_scores();

        // Extreme settings.
        write_reg(REG_BIAS, 18'h1FFFF);
        write_reg(REG_PENALTY, 18'h3FFFF);
        write_reg(REG_BONUS, 18'h1FFFF);
        write_reg(REG_SPAN, 18'd0);
        new_term(5);
        send_field(5);
        send_field(12);
        drain_scores();
        write_reg(REG_BIAS, 18'd0);
        write_reg(REG_PENALTY, 18'd0);
        write_reg(REG_BONUS, 18'd0);
        write_reg(REG_SPAN, 18'd32);
        send_field(3);
        drain_scores();

        // Field much longer than the term.
        new_term(3);
        for (int i = 0; i < 80; i++)
        begin
            send_item(ACT_FIELD, 16'h61);
        end
        send_item(ACT_END, 16'h0);
        drain_scores();

        // Receiver holds off while items keep coming, so the block stalls.
        hold_receiver = 1'b1;
        new_term(4);
        for (int i = 0; i < 6; i++)
        begin
            send_field(2);
        end
        drain_scores();

        // Random phases, each with its own settings.
        sent = 0;
        while (sent < 970)
        begin
            random_config();
            idle_enabled = (sent > 300);
            for (int f = 0; f < 12; f++)
            begin
                k = $urandom_range(9);
                if (k == 0)
                begin
                    new_term($urandom_range(36));
                    sent += term_text.size() + 1;
                end
                else if (k == 1)
                begin
                    send_item(action_t'(2'($urandom_range(3))),
                              16'($urandom_range(16'hFFFF)));
                    sent++;
                end
                else
                begin
                    if (term_text.size() == 0)
                    begin
                        new_term($urandom_range(1, 8));
                        sent += term_text.size() + 1;
                    end
                    k = $urandom_range(4) == 0 ? $urandom_range(40) : $urandom_range(8);
                    send_field(k);
                    sent += k + 1;
                end
            end
            drain_scores();
        end

        in_valid <= 1'b0;
        while (pending_scores != 0)
        begin
            @(posedge clk);
        end
        repeat (250) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_lcs_fuzzy_match_scorer: PASS");
        end
        else
        begin
            $display("tb_lcs_fuzzy_match_scorer: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
